// File: src/keyed_record_table_macros.svh
// Assertion macros for the keyed record table.
`ifndef KEYED_RECORD_TABLE_MACROS_SVH
`define KEYED_RECORD_TABLE_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define KRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define KRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/krt_pkg.sv
// Types and constants shared by the keyed record table.
package krt_pkg;

   localparam int SLOTS_DEF = 32;
   localparam int KEY_W     = 16;
   localparam int AGE_W     = 8;
   localparam int DIGITS_W  = 44;
   localparam int SLOT_W    = 5;
   localparam int STATUS_W  = 2;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_LOOKUP = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_FOUND     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

endpackage

// File: src/keyed_record_table.sv
// Keyed record table: content-addressable store of key, age and ID digits.
//
// Input channel: a request beat (req_type, req_key, req_age, req_id_digits)
// is taken at each rising edge with start high and busy low. busy is held
// low, so one beat can be taken every cycle.
// req_type selects insert (record goes to the lowest free slot) or lookup
// (record in the lowest slot holding a nonzero matching key comes back).
// Result channel: every request yields exactly one result beat, shown on
// the rsp_ ports for one cycle with rsp_valid high. The receiver cannot
// stall; results must be taken as they appear.
// Pipeline: the request is registered, then one pass of parallel key compare
// and priority encode over all slots updates the table and loads the
// result register, which drives rsp_valid and the rsp_ ports. Throughput
// is one request per cycle, set by that single compare-and-encode pass;
// a request sees the table as left by the one before it.
// Reset (synchronous, active high) frees every slot and drops any request
// or result in flight. Ages and digits are not cleared.
`include "keyed_record_table_macros.svh"

module keyed_record_table #(
   parameter int SLOTS = krt_pkg::SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [krt_pkg::KEY_W-1:0]     req_key,
   input  logic [krt_pkg::AGE_W-1:0]     req_age,
   input  logic [krt_pkg::DIGITS_W-1:0]  req_id_digits,
   output logic                          rsp_valid,
   output logic [krt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [krt_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [krt_pkg::AGE_W-1:0]     rsp_found_age,
   output logic [krt_pkg::DIGITS_W-1:0]  rsp_found_digits
);
   import krt_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // request register
   logic                req_valid_ff;
   req_kind_type        req_kind_ff;
   logic [KEY_W-1:0]    req_key_ff;
   logic [AGE_W-1:0]    req_age_ff;
   logic [DIGITS_W-1:0] req_digits_ff;

   // table
   logic [KEY_W-1:0]    slot_key_ff    [SLOTS];
   logic [AGE_W-1:0]    slot_age_ff    [SLOTS];
   logic [DIGITS_W-1:0] slot_digits_ff [SLOTS];

   // result register
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [AGE_W-1:0]    rsp_age_ff;
   logic [DIGITS_W-1:0] rsp_digits_ff;

   logic [SLOTS-1:0]    free_vec;
   logic [SLOTS-1:0]    match_vec;
   logic [IDX_W-1:0]    free_idx;
   logic [IDX_W-1:0]    match_idx;
   logic                any_free;
   logic                any_match;
   logic                do_write;
   logic                do_read;
   status_type          status_in;
   logic [SLOT_W-1:0]   slot_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      if (start && !busy) begin
         req_kind_ff   <= req_kind_type'(req_type);
         req_key_ff    <= req_key;
         req_age_ff    <= req_age;
         req_digits_ff <= req_id_digits;
      end
   end

   // parallel compare against every slot
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         free_vec[i]  = (slot_key_ff[i] == '0);
         match_vec[i] = (slot_key_ff[i] == req_key_ff) && (req_key_ff != '0);
      end
   end

   // lowest set bit wins: scan from the top so the lowest index is left
   always_comb begin
      free_idx  = '0;
      match_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            free_idx = IDX_W'(i);
         end
         if (match_vec[i]) begin
            match_idx = IDX_W'(i);
         end
      end
   end

   assign any_free  = |free_vec;
   assign any_match = |match_vec;
   assign do_write  = req_valid_ff && (req_kind_ff == REQ_INSERT) && any_free;
   assign do_read   = req_valid_ff && (req_kind_ff == REQ_LOOKUP) && any_match;

   always_comb begin
      status_in = ST_NOT_FOUND;
      slot_in   = '0;
      if (req_kind_ff == REQ_INSERT) begin
         if (any_free) begin
            status_in = ST_INSERTED;
            slot_in   = SLOT_W'(free_idx);
         end else begin
            status_in = ST_FULL;
         end
      end else if (any_match) begin
         status_in = ST_FOUND;
         slot_in   = SLOT_W'(match_idx);
      end
   end

   // keys reset to free; a key-zero insert writes its record yet leaves the slot free
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_key_ff[i] <= '0;
         end
      end else if (do_write) begin
         slot_key_ff[free_idx] <= req_key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         slot_age_ff[free_idx]    <= req_age_ff;
         slot_digits_ff[free_idx] <= req_digits_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      if (req_valid_ff) begin
         rsp_status_ff <= status_in;
         rsp_slot_ff   <= slot_in;
         rsp_age_ff    <= do_read ? slot_age_ff[match_idx] : '0;
         rsp_digits_ff <= do_read ? slot_digits_ff[match_idx] : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_found_age    = rsp_age_ff;
   assign rsp_found_digits = rsp_digits_ff;

   `KRT_ASSERT_NEXT(a_beat_gives_result, clock, reset, req_valid_ff, rsp_valid_ff,
                    "request beat produced no result beat")
   `KRT_ASSERT_NEXT(a_no_phantom_result, clock, reset, !req_valid_ff, !rsp_valid_ff,
                    "result beat without request")
   `KRT_ASSERT_NOW(a_miss_is_blank, clock, reset,
                   rsp_valid_ff && (rsp_status_ff != ST_FOUND),
                   (rsp_age_ff == '0) && (rsp_digits_ff == '0),
                   "record fields not zero on a miss")
   `KRT_ASSERT_NEXT(a_insert_lands, clock, reset, do_write,
                    slot_key_ff[$past(free_idx)] == $past(req_key_ff),
                    "inserted key not stored in chosen slot")

endmodule
